### hdl/positional_list_store_assert.svh
// Assertion macros for the positional list store.
// Depends on nothing; included by the top level, which checks its own logic.
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH
`ifndef SYNTH
`define PLS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("positional_list_store: check failed");
`define PLS_ASSERT_NEXT(lbl, clk, rst, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("positional_list_store: sequence check failed");
`else
`define PLS_ASSERT(lbl, clk, rst, prop)
`define PLS_ASSERT_NEXT(lbl, clk, rst, cond, prop)
`endif
`endif

### hdl/plc_pkg.sv
// Shared types and constants of the positional list store.
// Used by the cell, the read gather tree and the top level.
package plc_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 7;
  localparam int COUNT_W  = 7;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (LEN_W > POS_W) ? LEN_W : POS_W;
  localparam int GRP      = 8;
  localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

  typedef enum logic [OP_W-1:0] {
    OP_READ      = 3'd0,
    OP_INS_FRONT = 3'd1,
    OP_APPEND    = 3'd2,
    OP_INS_AT    = 3'd3,
    OP_DELETE    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic [CMP_W-1:0] pos;
  } cell_ctrl_t;

endpackage

### hdl/plc_cell.sv
// One slot of the list: holds an entry and shifts with its neighbors.
// Depends on plc_pkg for widths and the control struct.
module plc_cell (
  input  logic                        clk,
  input  plc_pkg::cell_ctrl_t         ctrl,
  input  logic [plc_pkg::CMP_W-1:0]   index,
  input  logic [plc_pkg::CMP_W-1:0]   read_pos,
  input  logic [plc_pkg::DATA_W-1:0]  ins_value,
  input  logic [plc_pkg::DATA_W-1:0]  left,
  input  logic [plc_pkg::DATA_W-1:0]  right,
  output logic [plc_pkg::DATA_W-1:0]  data,
  output logic [plc_pkg::DATA_W-1:0]  sel_data
);
  import plc_pkg::*;

  logic [DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    if (ctrl.ins) begin
      if (index > ctrl.pos) begin
        data_next = left;
      end else if (index == ctrl.pos) begin
        data_next = ins_value;
      end
    end else if (ctrl.del && index >= ctrl.pos) begin
      data_next = right;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign sel_data = (index == read_pos) ? data : '0;

endmodule

### hdl/plc_gather.sv
// Registered OR tree that merges the masked words of all cells.
// Depends on plc_pkg for capacity and group size.
module plc_gather (
  input  logic                       clk,
  input  logic [plc_pkg::DATA_W-1:0] words [plc_pkg::CAPACITY],
  output logic [plc_pkg::DATA_W-1:0] merged
);
  import plc_pkg::*;

  logic [DATA_W-1:0] grp_or_next [NGRP];
  logic [DATA_W-1:0] grp_or      [NGRP];

  always_comb begin
    int idx;
    for (int g = 0; g < NGRP; g++) begin
      grp_or_next[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        idx = g * GRP + k;
        if (idx < CAPACITY) begin
          grp_or_next[g] = grp_or_next[g] | words[idx];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_or <= grp_or_next;
  end

  always_comb begin
    merged = '0;
    for (int g = 0; g < NGRP; g++) begin
      merged = merged | grp_or[g];
    end
  end

endmodule

### hdl/positional_list_store.sv
// Positional list store: an ordered list of up to CAPACITY signed 32-bit words
// kept in a row of cells. Every word goes through capture, execute (all cells
// shift in parallel, read data is gathered into a registered OR tree) and finish
// into the output register. The next word is taken only after the previous one
// has been loaded into the output register, so a new word is never accepted
// while an earlier one is still in progress; while an earlier output word waits
// for out_ready, the finish step holds and the input stays closed.
// Depends on plc_pkg, plc_cell, plc_gather and positional_list_store_assert.svh.
`include "positional_list_store_assert.svh"

module positional_list_store (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [plc_pkg::OP_W-1:0]          operation,
  input  logic [plc_pkg::POS_W-1:0]         position,
  input  logic signed [plc_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [plc_pkg::DATA_W-1:0] read_value,
  output logic                              hit,
  output logic                              dropped,
  output logic [plc_pkg::COUNT_W-1:0]       count
);
  import plc_pkg::*;

  state_t            state, state_next;
  logic [LEN_W-1:0]  length, length_next;
  logic [OP_W-1:0]   item_op;
  logic [POS_W-1:0]  item_pos;
  logic [DATA_W-1:0] item_value;

  logic res_hit, res_drop, res_read;
  logic res_hit_next, res_drop_next;
  logic want_ins, want_del, full;
  logic [CMP_W-1:0] len_c, pos_c, ins_pos;
  cell_ctrl_t ctrl;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] sel_data  [CAPACITY];
  logic [DATA_W-1:0] merged;
  logic              out_load;

  assign len_c = CMP_W'(length);
  assign pos_c = CMP_W'(item_pos);
  assign full  = (length == LEN_W'(CAPACITY));

  always_comb begin
    want_ins     = 1'b0;
    want_del     = 1'b0;
    ins_pos      = '0;
    res_hit_next = 1'b0;
    unique case (item_op)
      OP_READ: begin
        res_hit_next = pos_c < len_c;
      end
      OP_INS_FRONT: begin
        want_ins = 1'b1;
      end
      OP_APPEND: begin
        want_ins = 1'b1;
        ins_pos  = len_c;
      end
      OP_INS_AT: begin
        want_ins = pos_c <= len_c;
        ins_pos  = pos_c;
      end
      OP_DELETE: begin
        want_del = pos_c < len_c;
        ins_pos  = pos_c;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctrl.ins      = (state == ST_EXEC) && want_ins && !full;
    ctrl.del      = (state == ST_EXEC) && want_del;
    ctrl.pos      = ins_pos;
    res_drop_next = want_ins && full;
    length_next   = length;
    if (ctrl.ins) begin
      length_next = length + LEN_W'(1);
    end else if (ctrl.del) begin
      length_next = length - LEN_W'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = cell_data[i+1];
    end
    plc_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .index    (CMP_W'(i)),
      .read_pos (pos_c),
      .ins_value(item_value),
      .left     (left_w),
      .right    (right_w),
      .data     (cell_data[i]),
      .sel_data (sel_data[i])
    );
  end

  plc_gather u_gather (
    .clk   (clk),
    .words (sel_data),
    .merged(merged)
  );

  always_comb begin
    in_ready   = (state == ST_IDLE);
    out_load   = (state == ST_DONE) && (!out_valid || out_ready);
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      length    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      length <= length_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_op    <= operation;
      item_pos   <= position;
      item_value <= value;
    end
    if (state == ST_EXEC) begin
      res_hit  <= res_hit_next;
      res_drop <= res_drop_next;
      res_read <= (item_op == OP_READ);
    end
    if (out_load) begin
      hit     <= res_hit;
      dropped <= res_drop;
      count   <= COUNT_W'(length);
      if (res_hit) begin
        read_value <= merged;
      end else if (res_read) begin
        read_value <= '1;
      end else begin
        read_value <= '0;
      end
    end
  end

  `PLS_ASSERT(a_len_bound, clk, rst, length <= LEN_W'(CAPACITY))
  `PLS_ASSERT_NEXT(a_accept_exec, clk, rst, in_valid && in_ready, state == ST_EXEC)
  `PLS_ASSERT(a_hit_no_drop, clk, rst, !(out_valid && hit && dropped))

endmodule
